// ===== sv/clock_offset_averaging_converter_unit_defines.svh =====
// Assertion macros for the clock offset averaging converter.
`ifndef CLOCK_OFFSET_AVERAGING_CONVERTER_UNIT_DEFINES_SVH
`define CLOCK_OFFSET_AVERAGING_CONVERTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property, checked outside reset.
`define COAC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define COAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define COAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define COAC_ASSERT(lbl, clk, rst_n, prop, msg)
`define COAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define COAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/coac_pkg.sv =====
// Shared constants and controller/datapath types for the offset averaging converter.
`timescale 1ns / 1ps
package coac_pkg;

	localparam int DATA_W      = 64;
	localparam int COUNT_BITS  = 10;
	localparam int NEED_W      = 10;
	localparam int CMP_W       = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
	localparam int DIV_STEPS   = DATA_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);

	localparam logic [NEED_W-1:0]     NEEDED_RESET = NEED_W'(10);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

	// Commands from the controller, at most one per cycle
	typedef struct packed {
		logic capture;
		logic accum;
		logic delta;
		logic sum;
		logic absval;
		logic load_div;
		logic div_step;
		logic sign;
		logic offset;
		logic emit;
	} coac_cmd_t;

	// Status back to the controller
	typedef struct packed {
		logic locked;
		logic out_free;
	} coac_stat_t;

endpackage

// ===== sv/coac_in_if.sv =====
// Request channel: timestamp to convert plus one calibration pair.
`timescale 1ns / 1ps
interface coac_in_if;
	import coac_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] domain_ns;
	logic signed [DATA_W-1:0] sample_domain_ns;
	logic signed [DATA_W-1:0] sample_wall_ns;

	modport source (output valid, output domain_ns, output sample_domain_ns,
		output sample_wall_ns, input ready);
	modport sink (input valid, input domain_ns, input sample_domain_ns,
		input sample_wall_ns, output ready);
endinterface

// ===== sv/coac_out_if.sv =====
// Result channel: converted timestamp, offset used and lock flag.
`timescale 1ns / 1ps
interface coac_out_if;
	import coac_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] wall_ns;
	logic signed [DATA_W-1:0] offset_ns;
	logic                     offset_locked;

	modport source (output valid, output wall_ns, output offset_ns,
		output offset_locked, input ready);
	modport sink (input valid, input wall_ns, input offset_ns,
		input offset_locked, output ready);
endinterface

// ===== sv/coac_cfg_if.sv =====
// Configuration write channel for the needed sample count.
`timescale 1ns / 1ps
interface coac_cfg_if;
	import coac_pkg::*;

	logic              valid;
	logic              ready;
	logic [NEED_W-1:0] needed_samples;

	modport source (output valid, output needed_samples, input ready);
	modport sink (input valid, input needed_samples, output ready);
endinterface

// ===== sv/clock_offset_averaging_converter_unit.sv =====
// One request at a time: a new one is taken only after the last is loaded as a result.
// Unlocked requests pass accumulate, delta, sum, abs, divide, sign, offset; locked ones
// skip to result load. The 64-step radix-2 divider makes one quotient bit per cycle.
// A result register lets the next request in while a result waits to be taken.
// Reset clears the calibration state and the lock; needed_samples resets to 10.
`timescale 1ns / 1ps
`include "clock_offset_averaging_converter_unit_defines.svh"
module clock_offset_averaging_converter_unit (
	input  logic       clk,
	input  logic       arst_n,
	coac_in_if.sink    req,
	coac_out_if.source rsp,
	coac_cfg_if.sink   cfg
);
	import coac_pkg::*;

	coac_cmd_t  cmd;
	coac_stat_t stat;

	assign cfg.ready = 1'b1;

	// Sequencer
	coac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Arithmetic and state
	coac_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.domain_ns        (req.domain_ns),
		.sample_domain_ns (req.sample_domain_ns),
		.sample_wall_ns   (req.sample_wall_ns),
		.cfg_we           (cfg.valid),
		.cfg_needed       (cfg.needed_samples),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.wall_ns          (rsp.wall_ns),
		.offset_ns        (rsp.offset_ns),
		.offset_locked    (rsp.offset_locked)
	);

	// Checks
	`COAC_ASSERT(a_cmd_onehot, clk, arst_n, $onehot0(cmd), "more than one command active")
	`COAC_ASSERT_IMPL(a_capture_hs, clk, arst_n, cmd.capture, req.valid && req.ready, "capture without request handshake")
	`COAC_ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, stat.out_free, "result loaded over a pending result")
	`COAC_ASSERT_NEXT(a_lock_sticky, clk, arst_n, stat.locked, stat.locked, "offset lock dropped")

endmodule

// ===== sv/coac_datapath.sv =====
// Datapath: calibration state, running sum, radix-2 divider and result register.
`timescale 1ns / 1ps
module coac_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  coac_pkg::coac_cmd_t               cmd,
	output coac_pkg::coac_stat_t              stat,
	input  logic signed [coac_pkg::DATA_W-1:0] domain_ns,
	input  logic signed [coac_pkg::DATA_W-1:0] sample_domain_ns,
	input  logic signed [coac_pkg::DATA_W-1:0] sample_wall_ns,
	input  logic                              cfg_we,
	input  logic [coac_pkg::NEED_W-1:0]       cfg_needed,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic signed [coac_pkg::DATA_W-1:0] wall_ns,
	output logic signed [coac_pkg::DATA_W-1:0] offset_ns,
	output logic                              offset_locked
);
	import coac_pkg::*;

	logic [DATA_W-1:0]     domain_q;
	logic [DATA_W-1:0]     sd_q;
	logic [DATA_W-1:0]     sw_q;
	logic [DATA_W-1:0]     pair_off_q;
	logic [DATA_W-1:0]     delta_q;
	logic [DATA_W-1:0]     ref_off_q;
	logic                  have_ref_q;
	logic [DATA_W-1:0]     sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  neg_q;
	logic [DATA_W-1:0]     mag_q;
	logic [DATA_W-1:0]     quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [DATA_W-1:0]     qsig_q;
	logic [DATA_W-1:0]     offset_q;
	logic                  locked_q;
	logic [NEED_W-1:0]     needed_q;
	logic                  out_valid_q;
	logic [DATA_W-1:0]     wall_o_q;
	logic [DATA_W-1:0]     off_o_q;
	logic                  lock_o_q;

	logic [DATA_W-1:0]     pair_off;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   trial_sub;
	logic                  trial_ge;

	// Offset of the current pair
	assign pair_off = sw_q - sd_q;

	// One restoring division step against the sample count
	assign trial     = {rem_q, quo_q[DATA_W-1]};
	assign trial_ge  = trial >= {1'b0, count_q};
	assign trial_sub = trial - {1'b0, count_q};

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			domain_q <= domain_ns;
			sd_q     <= sample_domain_ns;
			sw_q     <= sample_wall_ns;
		end
	end

	// Work registers of the averaging and division
	always_ff @(posedge clk) begin
		if (cmd.accum) begin
			pair_off_q <= pair_off;
		end
		if (cmd.delta) begin
			delta_q <= pair_off_q - ref_off_q;
		end
		if (cmd.absval) begin
			neg_q <= sum_q[DATA_W-1];
			mag_q <= sum_q[DATA_W-1] ? (DATA_W'(0) - sum_q) : sum_q;
		end
		if (cmd.load_div) begin
			quo_q <= mag_q + DATA_W'(count_q >> 1);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[DATA_W-2:0], trial_ge};
			rem_q <= trial_ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
		if (cmd.sign) begin
			qsig_q <= neg_q ? (DATA_W'(0) - quo_q) : quo_q;
		end
	end

	// Calibration state: reference, running sum, count, frozen offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_off_q  <= '0;
			have_ref_q <= 1'b0;
			sum_q      <= '0;
			count_q    <= '0;
			offset_q   <= '0;
			locked_q   <= 1'b0;
		end else begin
			if (cmd.accum) begin
				if (!have_ref_q) begin
					ref_off_q  <= pair_off;
					have_ref_q <= 1'b1;
				end
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end
			if (cmd.sum) begin
				sum_q <= sum_q + delta_q;
			end
			if (cmd.offset) begin
				offset_q <= ref_off_q + qsig_q;
				if (CMP_W'(count_q) >= CMP_W'(needed_q)) begin
					locked_q <= 1'b1;
				end
			end
		end
	end

	// Needed sample count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needed_q <= NEEDED_RESET;
		end else if (cfg_we) begin
			needed_q <= cfg_needed;
		end
	end

	// Result register: hold until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			wall_o_q <= domain_q + offset_q;
			off_o_q  <= offset_q;
			lock_o_q <= locked_q;
		end
	end

	assign stat.locked   = locked_q;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign wall_ns       = wall_o_q;
	assign offset_ns     = off_o_q;
	assign offset_locked = lock_o_q;

endmodule

// ===== sv/coac_ctrl.sv =====
// Controller: sequences capture, averaging, division and result load.
`timescale 1ns / 1ps
module coac_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  coac_pkg::coac_stat_t stat,
	output coac_pkg::coac_cmd_t  cmd
);
	import coac_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACCUM = 4'd1;
	localparam logic [3:0] ST_DELTA = 4'd2;
	localparam logic [3:0] ST_SUM   = 4'd3;
	localparam logic [3:0] ST_ABS   = 4'd4;
	localparam logic [3:0] ST_LOAD  = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_SIGN  = 4'd7;
	localparam logic [3:0] ST_OFF   = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	logic [3:0]        state_q;
	logic [3:0]        state_d;
	logic [STEP_W-1:0] step_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = stat.locked ? ST_EMIT : ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = ST_DELTA;
			end
			ST_DELTA: begin
				cmd.delta = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ABS;
			end
			ST_ABS: begin
				cmd.absval = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_div = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				cmd.sign = 1'b1;
				state_d  = ST_OFF;
			end
			ST_OFF: begin
				cmd.offset = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule
